// ----- rtl/rci_pkg.sv -----
// ----------------------------------------------------------------------------
// rci_pkg
// Shared types and constants for the unit cylinder intersection pipeline.
// ----------------------------------------------------------------------------
package rci_pkg;

  localparam int FRAC_BITS = 16;

  // 1.0 with 32 fraction bits
  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

  // ray values that ride along the whole pipeline
  typedef struct packed {
    logic signed [31:0] oz;
    logic signed [31:0] dz;
    logic [30:0]        maxd;
  } rci_geo_t;

  // sideband from the quadratic setup to the root stages
  typedef struct packed {
    logic [63:0] a;
    logic [63:0] bm;
    logic        bneg;
    rci_geo_t    geo;
    logic        miss;
  } rci_side_t;

endpackage

// ----- rtl/rci_front.sv -----
// ----------------------------------------------------------------------------
// rci_front
// Quadratic setup: coordinate clamp, a/b/c products, discriminant.
// Seven register stages.
// ----------------------------------------------------------------------------
module rci_front import rci_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [15:0]                   epsilon,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_z,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] dir_z,
  input  logic [30:0]                   max_distance,
  input  logic                          was_hit,
  output logic                          out_valid,
  output logic [127:0]                  d,
  output rci_side_t                     side
);

  localparam int EW = (COORD_WIDTH > 32) ? COORD_WIDTH : 33;

  function automatic logic signed [31:0] sat32(input logic signed [EW-1:0] v);
    logic hi_one;
    logic hi_zero;
    hi_one  = &v[EW-1:31];
    hi_zero = ~|v[EW-1:31];
    if (hi_one || hi_zero) begin
      sat32 = v[31:0];
    end else if (v[EW-1]) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'sh7fff_ffff;
    end
  endfunction

  logic signed [31:0] ox, oy, dx, dy;
  rci_geo_t           geo_in;

  assign ox = sat32(EW'(origin_x));
  assign oy = sat32(EW'(origin_y));
  assign dx = sat32(EW'(dir_x));
  assign dy = sat32(EW'(dir_y));
  assign geo_in.oz   = sat32(EW'(origin_z));
  assign geo_in.dz   = sat32(EW'(dir_z));
  assign geo_in.maxd = max_distance;

  // stage 1: products
  logic               s1_v, s1_flag;
  logic signed [63:0] s1_pxx, s1_pyy, s1_pxo, s1_pyo, s1_oxx, s1_oyy;
  rci_geo_t           s1_g;
  // stage 2: sums
  logic               s2_v, s2_flag;
  logic [63:0]        s2_a, s2_r;
  logic signed [64:0] s2_b;
  rci_geo_t           s2_g;
  // stage 3: magnitudes
  logic               s3_v, s3_bneg, s3_cadd, s3_flat;
  logic [63:0]        s3_a, s3_bm, s3_cm;
  rci_geo_t           s3_g;
  // stage 4: partial products
  logic               s4_v, s4_bneg, s4_cadd, s4_flat;
  logic [63:0]        s4_a, s4_bm;
  logic [63:0]        s4_bb00, s4_bb01, s4_bb11, s4_ac00, s4_ac01, s4_ac10, s4_ac11;
  rci_geo_t           s4_g;
  // stage 5: b^2 and a*c
  logic               s5_v, s5_bneg, s5_cadd, s5_flat;
  logic [63:0]        s5_a, s5_bm;
  logic [127:0]       s5_b2, s5_ac;
  rci_geo_t           s5_g;
  // stage 6: discriminant
  logic               s6_v, s6_bneg, s6_miss;
  logic [63:0]        s6_a, s6_bm;
  logic [127:0]       s6_d;
  rci_geo_t           s6_g;

  logic [63:0]  cm_next;
  logic         cneg_next;
  logic [128:0] diff;

  always_comb begin
    if (s2_r >= ONE_Q32) begin
      cm_next   = s2_r - ONE_Q32;
      cneg_next = 1'b0;
    end else begin
      cm_next   = ONE_Q32 - s2_r;
      cneg_next = 1'b1;
    end
    if (s2_flag) begin
      cm_next = '0;
    end
  end

  assign diff = {1'b0, s5_b2} - {1'b0, s5_ac};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
      out_valid <= s6_v;
    end
    if (en) begin
      s1_pxx  <= dx * dx;
      s1_pyy  <= dy * dy;
      s1_pxo  <= dx * ox;
      s1_pyo  <= dy * oy;
      s1_oxx  <= ox * ox;
      s1_oyy  <= oy * oy;
      s1_flag <= was_hit;
      s1_g    <= geo_in;

      s2_a    <= 64'(s1_pxx) + 64'(s1_pyy);
      s2_r    <= 64'(s1_oxx) + 64'(s1_oyy);
      s2_b    <= 65'(s1_pxo) + 65'(s1_pyo);
      s2_flag <= s1_flag;
      s2_g    <= s1_g;

      s3_a    <= s2_a;
      s3_bm   <= s2_b[64] ? 64'(-s2_b) : s2_b[63:0];
      s3_bneg <= s2_b[64];
      s3_cm   <= cm_next;
      s3_cadd <= cneg_next || (cm_next == '0);
      s3_flat <= (s2_a == '0) || (s2_a < {32'd0, epsilon, 16'd0});
      s3_g    <= s2_g;

      s4_bb00 <= s3_bm[31:0]  * s3_bm[31:0];
      s4_bb01 <= s3_bm[31:0]  * s3_bm[63:32];
      s4_bb11 <= s3_bm[63:32] * s3_bm[63:32];
      s4_ac00 <= s3_a[31:0]   * s3_cm[31:0];
      s4_ac01 <= s3_a[31:0]   * s3_cm[63:32];
      s4_ac10 <= s3_a[63:32]  * s3_cm[31:0];
      s4_ac11 <= s3_a[63:32]  * s3_cm[63:32];
      s4_a    <= s3_a;
      s4_bm   <= s3_bm;
      s4_bneg <= s3_bneg;
      s4_cadd <= s3_cadd;
      s4_flat <= s3_flat;
      s4_g    <= s3_g;

      s5_b2   <= 128'(s4_bb00) + (128'(s4_bb01) << 33) + (128'(s4_bb11) << 64);
      s5_ac   <= 128'(s4_ac00) + (128'(s4_ac01) << 32) + (128'(s4_ac10) << 32)
               + (128'(s4_ac11) << 64);
      s5_a    <= s4_a;
      s5_bm   <= s4_bm;
      s5_bneg <= s4_bneg;
      s5_cadd <= s4_cadd;
      s5_flat <= s4_flat;
      s5_g    <= s4_g;

      // subtracting a*c that exceeds b^2 means a negative discriminant
      s6_d    <= s5_cadd ? (s5_b2 + s5_ac) : diff[127:0];
      s6_miss <= s5_flat || (!s5_cadd && diff[128]);
      s6_a    <= s5_a;
      s6_bm   <= s5_bm;
      s6_bneg <= s5_bneg;
      s6_g    <= s5_g;

      d         <= s6_d;
      side.a    <= s6_a;
      side.bm   <= s6_bm;
      side.bneg <= s6_bneg;
      side.geo  <= s6_g;
      side.miss <= s6_miss || (s6_d < (128'(epsilon) << 48));
    end
  end

endmodule

// ----- rtl/rci_sqrt.sv -----
// ----------------------------------------------------------------------------
// rci_sqrt
// Pipelined integer square root of the 128-bit discriminant, one result
// bit per stage.
// ----------------------------------------------------------------------------
module rci_sqrt import rci_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [127:0] d,
  input  rci_side_t    in_side,
  output logic         out_valid,
  output logic [63:0]  root,
  output rci_side_t    out_side
);

  localparam int STEPS = 64;

  logic         v   [STEPS];
  logic [127:0] rem [STEPS];
  logic [63:0]  rt  [STEPS];
  rci_side_t    sd  [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam int K = STEPS - 1 - i;
    logic         v_in;
    logic [127:0] rem_in;
    logic [63:0]  rt_in;
    rci_side_t    sd_in;
    logic [127:0] trial;
    logic         ge;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign rem_in = d;
      assign rt_in  = '0;
      assign sd_in  = in_side;
    end else begin : g_next
      assign v_in   = v[i-1];
      assign rem_in = rem[i-1];
      assign rt_in  = rt[i-1];
      assign sd_in  = sd[i-1];
    end

    // (r + 2^K)^2 - r^2 = r*2^(K+1) + 2^(2K)
    assign trial = (128'(rt_in) << (K + 1)) | (128'd1 << (2 * K));
    assign ge    = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v_in;
      end
      if (en) begin
        rem[i] <= ge ? (rem_in - trial) : rem_in;
        rt[i]  <= ge ? (rt_in | (64'd1 << K)) : rt_in;
        sd[i]  <= sd_in;
      end
    end
  end

  assign out_valid = v[STEPS-1];
  assign root      = rt[STEPS-1];
  assign out_side  = sd[STEPS-1];

endmodule

// ----- rtl/rci_div.sv -----
// ----------------------------------------------------------------------------
// rci_div
// Both root numerators, then two lockstep restoring dividers by a,
// one quotient bit per stage, saturating at 2^32-1.
// ----------------------------------------------------------------------------
module rci_div import rci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] root,
  input  rci_side_t   in_side,
  output logic        out_valid,
  output logic [31:0] q_near,
  output logic [31:0] q_far,
  output logic        ok_near,
  output logic        ok_far,
  output rci_side_t   out_side
);

  localparam int QBITS = 32;

  typedef struct packed {
    logic        ok;
    logic        sat;
    logic [95:0] rem;
    logic [31:0] q;
  } rci_quo_t;

  // numerator stage
  logic        n_v, n_okn, n_okf;
  logic [64:0] n_numn, n_numf;
  rci_side_t   n_sd;
  logic [64:0] numf_next;
  logic        okf_next;
  // saturation stage
  logic        t_v;
  rci_quo_t    t_n, t_f;
  rci_side_t   t_sd;
  logic [95:0] shn, shf, a_top;

  always_comb begin
    if (in_side.bneg) begin
      numf_next = 65'(in_side.bm) + 65'(root);
      okf_next  = 1'b1;
    end else if (root > in_side.bm) begin
      numf_next = 65'(root - in_side.bm);
      okf_next  = 1'b1;
    end else begin
      numf_next = '0;
      okf_next  = 1'b0;
    end
  end

  assign shn   = 96'(n_numn) << FRAC_BITS;
  assign shf   = 96'(n_numf) << FRAC_BITS;
  assign a_top = 96'(n_sd.a) << QBITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v <= 1'b0;
      t_v <= 1'b0;
    end else if (en) begin
      n_v <= in_valid;
      t_v <= n_v;
    end
    if (en) begin
      n_okn  <= in_side.bneg && (in_side.bm > root);
      n_numn <= 65'(in_side.bm - root);
      n_okf  <= okf_next;
      n_numf <= numf_next;
      n_sd   <= in_side;

      t_n.ok  <= n_okn;
      t_n.sat <= shn >= a_top;
      t_n.rem <= shn;
      t_n.q   <= '0;
      t_f.ok  <= n_okf;
      t_f.sat <= shf >= a_top;
      t_f.rem <= shf;
      t_f.q   <= '0;
      t_sd    <= n_sd;
    end
  end

  logic      v   [QBITS];
  rci_quo_t  qn  [QBITS];
  rci_quo_t  qf  [QBITS];
  rci_side_t sd  [QBITS];

  for (genvar j = 0; j < QBITS; j++) begin : g_bit
    localparam int B = QBITS - 1 - j;
    logic        v_in;
    rci_quo_t    n_in, f_in;
    rci_side_t   sd_in;
    logic [95:0] sub;
    logic        ge_n, ge_f;

    if (j == 0) begin : g_first
      assign v_in  = t_v;
      assign n_in  = t_n;
      assign f_in  = t_f;
      assign sd_in = t_sd;
    end else begin : g_next
      assign v_in  = v[j-1];
      assign n_in  = qn[j-1];
      assign f_in  = qf[j-1];
      assign sd_in = sd[j-1];
    end

    assign sub  = 96'(sd_in.a) << B;
    assign ge_n = n_in.rem >= sub;
    assign ge_f = f_in.rem >= sub;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (en) begin
        v[j] <= v_in;
      end
      if (en) begin
        qn[j].ok  <= n_in.ok;
        qn[j].sat <= n_in.sat;
        qn[j].rem <= ge_n ? (n_in.rem - sub) : n_in.rem;
        qn[j].q   <= n_in.q | (32'(ge_n) << B);
        qf[j].ok  <= f_in.ok;
        qf[j].sat <= f_in.sat;
        qf[j].rem <= ge_f ? (f_in.rem - sub) : f_in.rem;
        qf[j].q   <= f_in.q | (32'(ge_f) << B);
        sd[j]     <= sd_in;
      end
    end
  end

  assign out_valid = v[QBITS-1];
  assign q_near    = qn[QBITS-1].sat ? '1 : qn[QBITS-1].q;
  assign q_far     = qf[QBITS-1].sat ? '1 : qf[QBITS-1].q;
  assign ok_near   = qn[QBITS-1].ok;
  assign ok_far    = qf[QBITS-1].ok;
  assign out_side  = sd[QBITS-1];

endmodule

// ----- rtl/rci_check.sv -----
// ----------------------------------------------------------------------------
// rci_check
// Range and height tests on both roots, nearer root preferred.
// One register stage, result left combinational for the output register.
// ----------------------------------------------------------------------------
module rci_check import rci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [15:0] epsilon,
  input  logic        in_valid,
  input  logic [31:0] q_near,
  input  logic [31:0] q_far,
  input  logic        ok_near,
  input  logic        ok_far,
  input  rci_side_t   in_side,
  output logic        out_valid,
  output logic        hit,
  output logic [30:0] distance
);

  logic               c_v, c_rngn, c_rngf, c_miss;
  logic signed [64:0] c_zpn, c_zpf;
  logic [30:0]        c_qn, c_qf, c_maxd;
  logic signed [31:0] c_oz;

  logic signed [65:0] zn, zf, oz_sh;
  logic               hit_n, hit_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= in_valid;
    end
    if (en) begin
      c_rngn <= ok_near && (q_near > 32'(epsilon)) && (q_near < 32'(in_side.geo.maxd));
      c_rngf <= ok_far  && (q_far  > 32'(epsilon)) && (q_far  < 32'(in_side.geo.maxd));
      c_zpn  <= $signed({1'b0, q_near}) * in_side.geo.dz;
      c_zpf  <= $signed({1'b0, q_far})  * in_side.geo.dz;
      c_qn   <= q_near[30:0];
      c_qf   <= q_far[30:0];
      c_maxd <= in_side.geo.maxd;
      c_oz   <= in_side.geo.oz;
      c_miss <= in_side.miss;
    end
  end

  // height with 32 fraction bits must lie strictly inside (0, 1)
  assign oz_sh = 66'(c_oz) <<< FRAC_BITS;
  assign zn    = 66'(c_zpn) + oz_sh;
  assign zf    = 66'(c_zpf) + oz_sh;
  assign hit_n = !c_miss && c_rngn && (zn > 66'sd0) && (zn < (66'sd1 <<< 32));
  assign hit_f = !c_miss && c_rngf && (zf > 66'sd0) && (zf < (66'sd1 <<< 32));

  assign out_valid = c_v;
  assign hit       = hit_n || hit_f;
  assign distance  = hit_n ? c_qn : (hit_f ? c_qf : c_maxd);

endmodule

// ----- rtl/ray_unit_cylinder_intersect_top.sv -----
// Stages: 107 register stages from an accepted ray to its result (7 setup,
// 64 square-root, 34 divide, 1 check, 1 output).
// Throughput: one ray per cycle while the skid is empty; square-root and divider
// bit stages are fully pipelined; the skid keeps input open while a result waits.
// Reset: rst clears all valid bits and sets epsilon to 1; no clearing pass.
// ----------------------------------------------------------------------------
// ray_unit_cylinder_intersect_top
// Ray against the side of the unit cylinder, 0 < z < 1, in Q16.16.
// ----------------------------------------------------------------------------
module ray_unit_cylinder_intersect_top import rci_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [15:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_z,
  input  logic signed [COORD_WIDTH-1:0] dir_x,
  input  logic signed [COORD_WIDTH-1:0] dir_y,
  input  logic signed [COORD_WIDTH-1:0] dir_z,
  input  logic [30:0]                   max_distance,
  input  logic                          was_hit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [30:0]                   distance
);

  logic [15:0]  epsilon;
  logic         en;

  logic         f_v, s_v, dv_v, ck_v;
  logic [127:0] f_d;
  rci_side_t    f_sd, s_sd, dv_sd;
  logic [63:0]  s_root;
  logic [31:0]  dv_qn, dv_qf;
  logic         dv_okn, dv_okf;
  logic         ck_hit;
  logic [30:0]  ck_dist;

  logic         r_v, r_hit, skid_v, skid_hit;
  logic [30:0]  r_dist, skid_dist;

  // pipeline moves whenever the skid stage is free
  assign en       = !skid_v;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= 16'd1;
    end else if (cfg_we) begin
      epsilon <= cfg_wdata;
    end
  end

  rci_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst, .en, .epsilon, .in_valid,
    .origin_x, .origin_y, .origin_z, .dir_x, .dir_y, .dir_z,
    .max_distance, .was_hit,
    .out_valid (f_v),
    .d         (f_d),
    .side      (f_sd)
  );

  rci_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid  (f_v),
    .d         (f_d),
    .in_side   (f_sd),
    .out_valid (s_v),
    .root      (s_root),
    .out_side  (s_sd)
  );

  rci_div u_div (
    .clk, .rst, .en,
    .in_valid  (s_v),
    .root      (s_root),
    .in_side   (s_sd),
    .out_valid (dv_v),
    .q_near    (dv_qn),
    .q_far     (dv_qf),
    .ok_near   (dv_okn),
    .ok_far    (dv_okf),
    .out_side  (dv_sd)
  );

  rci_check u_check (
    .clk, .rst, .en, .epsilon,
    .in_valid  (dv_v),
    .q_near    (dv_qn),
    .q_far     (dv_qf),
    .ok_near   (dv_okn),
    .ok_far    (dv_okf),
    .in_side   (dv_sd),
    .out_valid (ck_v),
    .hit       (ck_hit),
    .distance  (ck_dist)
  );

  // output register plus skid: an unaccepted result moves to the skid
  // stage so the pipeline can advance one more time
  always_ff @(posedge clk) begin
    if (rst) begin
      r_v    <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (out_ready) begin
        skid_v <= 1'b0;
      end
    end else begin
      r_v    <= ck_v;
      r_hit  <= ck_hit;
      r_dist <= ck_dist;
      if (r_v && !out_ready) begin
        skid_v    <= 1'b1;
        skid_hit  <= r_hit;
        skid_dist <= r_dist;
      end
    end
  end

  assign out_valid = skid_v || r_v;
  assign hit       = skid_v ? skid_hit  : r_hit;
  assign distance  = skid_v ? skid_dist : r_dist;

endmodule

// ----- rtl/rci_checker.sv -----
// ----------------------------------------------------------------------------
// rci_checker
// Port-level checks on the cylinder intersection block, bound to the top.
// ----------------------------------------------------------------------------
module rci_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [15:0] cfg_wdata,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [30:0] distance
);

  logic [15:0] eps_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps_seen <= 16'd1;
    end else if (cfg_we) begin
      eps_seen <= cfg_wdata;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(distance))
    else $error("result changed while stalled");

  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> distance > {15'd0, eps_seen})
    else $error("hit distance not above epsilon");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result waiting");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind ray_unit_cylinder_intersect_top rci_checker u_rci_checker (.*);

// ----- tb/ray_unit_cylinder_intersect_checker.sv -----
// ----------------------------------------------------------------------------
// ray_unit_cylinder_intersect_checker
// Watches the ray and result channels, computes the expected hit and distance
// for every accepted ray and compares them with each accepted result.
// ----------------------------------------------------------------------------
module ray_unit_cylinder_intersect_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic [30:0]        max_distance,
  input  logic               was_hit,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               hit,
  input  logic [30:0]        distance,
  output int                 errors,
  output int                 pending,
  output int                 hits_seen,
  output int                 results_seen
);

  typedef struct packed {
    logic        hit;
    logic [30:0] dist_val;
  } cyl_result_t;

  logic [15:0] eps;
  cyl_result_t hits_q[$];

  // candidate root: numerator (32 fraction bits) << 16 over a, saturated
  function automatic logic try_root(input logic [64:0] num, input logic [63:0] a,
                                    input logic signed [31:0] oz,
                                    input logic signed [31:0] dz,
                                    input logic [30:0] maxd,
                                    output logic [31:0] t);
    logic [127:0] q;
    logic [31:0] qs;
    logic signed [95:0] z;
    q = {num, 16'b0} / {64'b0, a};
    qs = (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    t = qs;
    if (!(qs > {16'b0, eps} && qs < {1'b0, maxd})) return 1'b0;
    z = $signed({64'b0, qs}) * dz + ($signed({{64{oz[31]}}, oz}) <<< 16);
    return z > 0 && z < (96'sd1 <<< 32);
  endfunction

  function automatic cyl_result_t predict_hit(
      input logic signed [31:0] ox, oy, oz, dx, dy, dz,
      input logic [30:0] maxd, input logic flag);
    cyl_result_t res;
    logic [63:0] a, r, cm, s, bm;
    logic signed [64:0] bsum;
    logic bneg, cneg, ok;
    logic [127:0] b2, ac, d;
    logic [64:0] num;
    logic [31:0] t;
    res.hit = 1'b0;
    res.dist_val = maxd;
    a = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
    if (a == 0 || a < ({48'b0, eps} << 16)) return res;
    bsum = 65'(64'(dx) * 64'(ox)) + 65'(64'(dy) * 64'(oy));
    bneg = bsum < 0;
    bm = bneg ? 64'(-bsum) : 64'(bsum);
    r = 64'(ox) * 64'(ox) + 64'(oy) * 64'(oy);
    cneg = r < 64'h1_0000_0000;
    cm = cneg ? 64'h1_0000_0000 - r : r - 64'h1_0000_0000;
    if (flag) cm = 0;
    b2 = {64'b0, bm} * {64'b0, bm};
    ac = {64'b0, a} * {64'b0, cm};
    if (cm == 0 || cneg) d = b2 + ac;
    else begin
      if (b2 < ac) return res;
      d = b2 - ac;
    end
    if (d < ({112'b0, eps} << 48)) return res;
    s = 0;
    for (int k = 63; k >= 0; k--) begin
      logic [63:0] c;
      c = s | (64'd1 << k);
      if ({64'b0, c} * {64'b0, c} <= d) s = c;
    end
    ok = 1'b0;
    if (bneg && bm > s) ok = try_root({1'b0, bm - s}, a, oz, dz, maxd, t);
    if (!ok) begin
      if (bneg) ok = try_root({1'b0, bm} + {1'b0, s}, a, oz, dz, maxd, t);
      else if (s > bm) ok = try_root({1'b0, s - bm}, a, oz, dz, maxd, t);
    end
    if (ok) begin
      res.hit = 1'b1;
      res.dist_val = t[30:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cyl_result_t want;
    if (rst) begin
      eps <= 16'd1;
      errors <= 0;
      pending <= 0;
      hits_seen <= 0;
      results_seen <= 0;
      hits_q.delete();
    end else begin
      if (cfg_we) eps <= cfg_wdata;
      if (in_valid && in_ready)
        hits_q.push_back(predict_hit(origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                                     max_distance, was_hit));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (hit) hits_seen <= hits_seen + 1;
        if (hits_q.size() == 0) begin
          $display("%0t: result with nothing expected: hit=%0b distance=%h",
                   $time, hit, distance);
          errors <= errors + 1;
        end else begin
          want = hits_q.pop_front();
          if (want.hit !== hit || want.dist_val !== distance) begin
            $display("%0t: mismatch expected hit=%0b distance=%h actual hit=%0b distance=%h",
                     $time, want.hit, want.dist_val, hit, distance);
            errors <= errors + 1;
          end
        end
      end
      pending <= hits_q.size();
    end
  end

endmodule

// ----- tb/ray_unit_cylinder_intersect_top_tb.sv -----
// ----------------------------------------------------------------------------
// ray_unit_cylinder_intersect_top_tb
// Drives directed and random rays under several epsilon values with random
// idling on both sides and a long output stall; the checker does the scoring.
// ----------------------------------------------------------------------------
module ray_unit_cylinder_intersect_top_tb;

  localparam int LATENCY = 107;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  logic clk, rst, cfg_we;
  logic [15:0] cfg_wdata;
  logic in_valid, in_ready, out_valid, out_ready, hit, was_hit;
  logic signed [31:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
  logic [30:0] max_distance, distance;
  int errors, pending, hits_seen, results_seen;
  int sent;
  logic stall_long, rx_quiet, tx_quiet;

  ray_unit_cylinder_intersect_top uut (.*);

  ray_unit_cylinder_intersect_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random back-pressure, a quiet stretch, and one long hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !stall_long && (rx_quiet || $urandom_range(99) >= 7);
  end

  initial begin
    stall_long = 1'b0;
    rx_quiet = 1'b0;
    wait (sent >= 600);
    @(posedge clk) stall_long <= 1'b1;
    repeat (400) @(posedge clk);
    stall_long <= 1'b0;
    wait (sent >= 1000);
    @(posedge clk) rx_quiet <= 1'b1;
    wait (sent >= 1300);
    @(posedge clk) rx_quiet <= 1'b0;
  end

  function automatic logic signed [31:0] rnd_coord(input int sel);
    case (sel)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 * 65536)) - ONE;
      default: return $signed($urandom_range(0, 8 * 65536)) - 4 * ONE;
    endcase
  endfunction

  task automatic send_ray(input logic signed [31:0] ox, oy, oz, dx, dy, dz,
                          input logic [30:0] maxd, input logic flag);
    while (!tx_quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    origin_x <= ox; origin_y <= oy; origin_z <= oz;
    dir_x <= dx; dir_y <= dy; dir_z <= dz;
    max_distance <= maxd; was_hit <= flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic random_ray();
    int sel;
    logic signed [31:0] ox, oy, oz;
    logic [30:0] maxd;
    sel = $urandom_range(9);
    if (sel < 7) begin
      // ray from near the cylinder, outside or inside, in a random direction
      ox = rnd_coord(2); oy = rnd_coord(2); oz = rnd_coord(1) + ONE / 2;
      maxd = (sel < 6) ? 31'($urandom_range(1, 64 * 65536)) : 31'($urandom);
      send_ray(ox, oy, oz, rnd_coord(2), rnd_coord(2), rnd_coord(2) >>> 1,
               maxd, $urandom_range(3) == 0);
    end else
      send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               31'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_eps(input logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] eps_set[4];
    eps_set = '{16'd0, 16'd300, 16'hFFFF, 16'd1};
    sent = 0;
    tx_quiet = 1'b0;
    rst = 1'b1; cfg_we = 1'b0; cfg_wdata = '0; in_valid = 1'b0;
    origin_x = '0; origin_y = '0; origin_z = '0;
    dir_x = '0; dir_y = '0; dir_z = '0; max_distance = '0; was_hit = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: through the side, from inside, grazing, flat, extremes
    send_ray(-2 * ONE, 0, ONE / 2, ONE, 0, 0, 31'h7FFF_FFFF, 1'b0);
    send_ray(-2 * ONE, 0, ONE / 2, ONE, 0, 0, 31'h7FFF_FFFF, 1'b1);
    send_ray(0, 0, ONE / 2, ONE, ONE, 0, 31'h7FFF_FFFF, 1'b0);
    send_ray(-2 * ONE, ONE, ONE / 2, ONE, 0, 0, 31'h7FFF_FFFF, 1'b0);
    send_ray(-2 * ONE, 2 * ONE, ONE / 2, ONE, 0, 0, 31'h7FFF_FFFF, 1'b0);
    send_ray(0, 0, 0, 0, 0, ONE, 31'h7FFF_FFFF, 1'b0);
    send_ray(-2 * ONE, 0, ONE / 2, 1, 0, 0, 31'h7FFF_FFFF, 1'b0);
    send_ray(-2 * ONE, 0, ONE / 2, ONE, 0, 0, 31'd0, 1'b0);
    send_ray(-2 * ONE, 0, ONE / 2, ONE, 0, 0, 31'h1_0000, 1'b0);
    send_ray(2 * ONE, 0, ONE / 2, ONE, 0, 0, 31'h7FFF_FFFF, 1'b0);
    send_ray(-2 * ONE, 0, 2 * ONE, ONE, 0, 0, 31'h7FFF_FFFF, 1'b0);
    send_ray(-2 * ONE, 0, ONE / 2, ONE, 0, 4 * ONE, 31'h7FFF_FFFF, 1'b0);
    send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
             32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 1'b1);
    send_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    send_ray(32'sh7FFF_FFFF, 0, ONE / 2, 32'sh8000_0000, 0, 0, 31'h7FFF_FFFF, 1'b0);
    send_ray(-1, -1, -1, -1, -1, -1, 31'h7FFF_FFFF, 1'b0);
    drain();

    for (int p = 0; p < 4; p++) begin
      set_eps(eps_set[p]);
      for (int i = 0; i < 480; i++) begin
        if (p == 2 && i == 100) tx_quiet = 1'b1;
        if (p == 2 && i == 300) tx_quiet = 1'b0;
        random_ray();
      end
      drain();
    end

    $display("Sent %0d rays over four epsilon settings; %0d results, %0d hits.",
             sent, results_seen, hits_seen);
    if (errors == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
